/* hw/rtl/goertzel_tone_magnitude_defines.svh */
// Assertion macros for the Goertzel tone magnitude block.
// Used by the port-level checker; expects clk_i and rst_ni in scope.
`ifndef GOERTZEL_TONE_MAGNITUDE_DEFINES_SVH
`define GOERTZEL_TONE_MAGNITUDE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define GTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define GTM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* hw/rtl/gtm_pkg.sv */
// Shared types and constants for the Goertzel tone magnitude block.
// No dependencies; imported by every RTL module of the block but gtm_queue.
package gtm_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned MagW     = 32;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RootInW  = 2 * MagW;
  localparam int unsigned StepW    = $clog2(MagW);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCoef     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMidpoint = CfgIdxW'(1);

  localparam logic [SampleW-1:0] MidpointReset = SampleW'(512);

  // Sequencer of the magnitude engine.
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQ1    = 8'b0000_0010,
    ST_SQ2    = 8'b0000_0100,
    ST_CROSS  = 8'b0000_1000,
    ST_TERM   = 8'b0001_0000,
    ST_POWER  = 8'b0010_0000,
    ST_ROOT   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } gtm_back_state_e;

  // Request to and response from the square root unit.
  typedef struct packed {
    logic               start;
    logic [RootInW-1:0] radicand;
  } gtm_root_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] root;
  } gtm_root_rsp_t;

endpackage

/* hw/rtl/gtm_queue.sv */
// Small register queue between the recurrence front end and the magnitude engine.
// Depends on nothing but its parameters.
module gtm_queue #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* hw/rtl/gtm_front.sv */
// Front end: configuration registers, sample intake and the Goertzel recurrence.
// Depends on gtm_pkg; hands finished blocks to gtm_queue.
module gtm_front
  import gtm_pkg::*;
#(
  parameter int unsigned ACC_WIDTH      = 32,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CfgIdxW-1:0]              cfg_idx_i,
  input  logic [CfgDataW-1:0]             cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SampleW-1:0]              sample_i,
  input  logic                            last_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output logic [2*ACC_WIDTH+CoefW-1:0]    push_data_o
);

  localparam int unsigned MulW = ACC_WIDTH + CoefW;
  localparam int unsigned PrW  = MulW + 1;
  localparam int unsigned SumW = PrW + 2;

  localparam logic signed [PrW-1:0] Rnd =
    {{(PrW - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [SumW-1:0] AccMax =
    {{(SumW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SumW-1:0] AccMin =
    {{(SumW - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};

  logic signed [CoefW-1:0]     coef_q;
  logic        [SampleW-1:0]   mid_q;
  logic signed [ACC_WIDTH-1:0] q1_q, q2_q, q0;
  logic signed [MulW-1:0]      prod_full;
  logic signed [PrW-1:0]       prod_q, prod_d, rnd_sum, rounded;
  logic signed [SampleW:0]     x_q, x_d;
  logic signed [SumW-1:0]      acc_sum;
  logic                        last_q, busy_q, accept, commit;

  // Stage one: product of the coefficient with q1, and the centred sample.
  assign accept    = in_valid_i && !busy_q;
  assign prod_full = coef_q * q1_q;
  assign prod_d    = PrW'(prod_full);
  assign x_d       = $signed({1'b0, sample_i}) - $signed({1'b0, mid_q});

  // Stage two: round half up, add, saturate.
  assign rnd_sum = prod_q + Rnd;
  assign rounded = rnd_sum >>> COEF_FRAC_BITS;
  assign acc_sum = SumW'(rounded) - SumW'(q2_q) + SumW'(x_q);

  always_comb begin
    if (acc_sum > AccMax) begin
      q0 = AccMax[ACC_WIDTH-1:0];
    end else if (acc_sum < AccMin) begin
      q0 = AccMin[ACC_WIDTH-1:0];
    end else begin
      q0 = acc_sum[ACC_WIDTH-1:0];
    end
  end

  // A last sample waits in stage two until the queue has room.
  assign commit       = busy_q && (!last_q || push_ready_i);
  assign in_stall_o   = busy_q;
  assign push_valid_o = busy_q && last_q;
  assign push_data_o  = {q0, q1_q, coef_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      mid_q  <= MidpointReset;
      q1_q   <= '0;
      q2_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegCoef:     coef_q <= cfg_wdata_i[CoefW-1:0];
          RegMidpoint: mid_q  <= cfg_wdata_i[SampleW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (commit) begin
        if (last_q) begin
          q1_q <= '0;
          q2_q <= '0;
        end else begin
          q1_q <= q0;
          q2_q <= q1_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
      x_q    <= x_d;
      last_q <= last_i;
    end
  end

endmodule

/* hw/rtl/gtm_isqrt.sv */
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Depends on gtm_pkg for the request and response types.
module gtm_isqrt
  import gtm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gtm_root_req_t req_i,
  output gtm_root_rsp_t rsp_o
);

  logic [RootInW-1:0] rem_q, res_q, bit_w, trial;
  logic [StepW-1:0]   cnt_q;
  logic               busy_q, done_q, fits;

  assign bit_w = RootInW'(1) << {cnt_q, 1'b0};
  assign trial = res_q + bit_w;
  assign fits  = (rem_q >= trial);

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
      done_q <= busy_q && (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.radicand;
      res_q <= '0;
      cnt_q <= StepW'(MagW - 1);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_w;
      end else begin
        res_q <= res_q >> 1;
      end
      cnt_q <= cnt_q - StepW'(1);
    end
  end

endmodule

/* hw/rtl/gtm_back.sv */
// Magnitude engine: shift-add products, power with clamping, square root, output register.
// Depends on gtm_pkg and gtm_isqrt; takes finished blocks from gtm_queue.
module gtm_back
  import gtm_pkg::*;
#(
  parameter int unsigned ACC_WIDTH      = 32,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  logic [2*ACC_WIDTH+CoefW-1:0] pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [MagW-1:0]              magnitude_o
);

  localparam int unsigned ProdW = 2 * ACC_WIDTH + CoefW;
  localparam int unsigned PwrW  = ProdW + 1;

  gtm_back_state_e      state_q, state_d;
  logic [ACC_WIDTH-1:0] q1_w, q2_w, a1, a2;
  logic [CoefW-1:0]     c_w, ac;
  logic                 neg;
  logic [ACC_WIDTH-1:0] a1_q, a1_d, a2_q, a2_d, mul_b_q, mul_b_d;
  logic [CoefW-1:0]     ac_q, ac_d;
  logic                 neg_q, neg_d;
  logic [ProdW-1:0]     mul_a_q, mul_a_d, acc_q, acc_d, sq_q, sq_d;
  logic [ProdW-1:0]     acc_step, tsh, tadj;
  logic [MagW-1:0]      res_q, res_d, mag_q;
  logic [PwrW-1:0]      sum_pos, diff, power;
  logic                 mul_done, frac, under, over, load_out, out_valid_q;
  gtm_root_req_t        root_req;
  gtm_root_rsp_t        root_rsp;

  // Entry layout: q1, q2, coefficient.
  assign q1_w = pop_data_i[ProdW-1 -: ACC_WIDTH];
  assign q2_w = pop_data_i[CoefW +: ACC_WIDTH];
  assign c_w  = pop_data_i[CoefW-1:0];
  assign a1   = q1_w[ACC_WIDTH-1] ? (~q1_w + ACC_WIDTH'(1)) : q1_w;
  assign a2   = q2_w[ACC_WIDTH-1] ? (~q2_w + ACC_WIDTH'(1)) : q2_w;
  assign ac   = c_w[CoefW-1] ? (~c_w + CoefW'(1)) : c_w;
  // The cross term only counts as negative when none of its factors is zero.
  assign neg  = (q1_w[ACC_WIDTH-1] ^ q2_w[ACC_WIDTH-1] ^ c_w[CoefW-1]) &&
                (q1_w != '0) && (q2_w != '0) && (c_w != '0);

  // One bit of the multiplier per cycle; a product ends when no set bit is left.
  assign mul_done = (mul_b_q == '0);
  assign acc_step = mul_b_q[0] ? (acc_q + mul_a_q) : acc_q;

  // Power from the squares and the scaled cross term held in the accumulator.
  assign frac    = |acc_q[COEF_FRAC_BITS-1:0];
  assign tsh     = acc_q >> COEF_FRAC_BITS;
  assign tadj    = tsh + ProdW'(neg_q && frac);
  assign sum_pos = {1'b0, sq_q} + {1'b0, tadj};
  assign diff    = {1'b0, sq_q} - {1'b0, tsh};
  assign under   = (sq_q < tsh);
  assign power   = neg_q ? sum_pos : (under ? '0 : diff);
  assign over    = |power[PwrW-1:RootInW];

  always_comb begin
    state_d  = state_q;
    a1_d     = a1_q;
    a2_d     = a2_q;
    ac_d     = ac_q;
    neg_d    = neg_q;
    mul_a_d  = mul_a_q;
    mul_b_d  = mul_b_q;
    acc_d    = acc_q;
    sq_d     = sq_q;
    res_d    = res_q;
    load_out = 1'b0;
    root_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          a1_d    = a1;
          a2_d    = a2;
          ac_d    = ac;
          neg_d   = neg;
          mul_a_d = ProdW'(a1);
          mul_b_d = a1;
          acc_d   = '0;
          state_d = ST_SQ1;
        end
      end
      ST_SQ1: begin
        if (mul_done) begin
          mul_a_d = ProdW'(a2_q);
          mul_b_d = a2_q;
          state_d = ST_SQ2;
        end else begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end
      end
      ST_SQ2: begin
        if (mul_done) begin
          sq_d    = acc_q;
          acc_d   = '0;
          mul_a_d = ProdW'(a1_q);
          mul_b_d = a2_q;
          state_d = ST_CROSS;
        end else begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end
      end
      ST_CROSS: begin
        if (mul_done) begin
          mul_a_d = acc_q;
          mul_b_d = ACC_WIDTH'(ac_q);
          acc_d   = '0;
          state_d = ST_TERM;
        end else begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end
      end
      ST_TERM: begin
        if (mul_done) begin
          state_d = ST_POWER;
        end else begin
          acc_d   = acc_step;
          mul_a_d = mul_a_q << 1;
          mul_b_d = mul_b_q >> 1;
        end
      end
      ST_POWER: begin
        if (over) begin
          res_d   = '1;
          state_d = ST_FINISH;
        end else begin
          root_req.start    = 1'b1;
          root_req.radicand = power[RootInW-1:0];
          state_d           = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_rsp.done) begin
          res_d   = root_rsp.root;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  gtm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q    <= a1_d;
    a2_q    <= a2_d;
    ac_q    <= ac_d;
    neg_q   <= neg_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    res_q   <= res_d;
    if (load_out) begin
      mag_q <= res_q;
    end
  end

endmodule

/* hw/rtl/goertzel_tone_magnitude.sv */
// Goertzel tone magnitude, top level. Uses gtm_pkg, gtm_front, gtm_queue and gtm_back.
// The sample rate is set by the recurrence loop (multiply, then add): a new sample is
// taken only once the last one is committed, and the engine takes a block only when idle.
// With the engine free, a block's magnitude follows its last sample through the shift-add
// products and the 32-step square root.
// Reset (asynchronous, active low): state words zero, coef 0, midpoint 512, queue empty.
module goertzel_tone_magnitude
  import gtm_pkg::*;
#(
  parameter int unsigned ACC_WIDTH      = 32,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port; index 0 is the coefficient, index 1 the midpoint.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Sample channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                last_i,
  // Result channel, one word per block.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MagW-1:0]     magnitude_o
);

  // Each queue entry carries the final q1, q2 and the coefficient in force.
  localparam int unsigned EntW = 2 * ACC_WIDTH + CoefW;

  logic            push_valid, push_ready, pop_valid, pop_ready;
  logic [EntW-1:0] push_data, pop_data;

  // The front end takes a sample, registers coef*q1 and then forms the rounded,
  // saturated new state from it. On the sample marked last it
  // pushes the block's final state into the queue and clears q1 and q2, so the
  // next block can start at once while the engine is still busy.
  gtm_front #(
    .ACC_WIDTH      (ACC_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Two entries let the front end keep running over short blocks while the
  // engine works out an earlier magnitude.
  gtm_queue #(
    .WIDTH (EntW),
    .DEPTH (2)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  // The engine forms q1^2 + q2^2 and the cross term with one shared shift-add
  // multiplier, clamps a negative power to zero, saturates a power that does
  // not fit in 64 bits, and otherwise takes the floor square root. The result
  // word sits in an output register, so the engine can take the next entry
  // while the word still waits to be taken.
  gtm_back #(
    .ACC_WIDTH      (ACC_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .magnitude_o (magnitude_o)
  );

endmodule

/* hw/rtl/gtm_checker.sv */
// Port-level checker for the Goertzel tone magnitude block, bound to the top level.
// Depends on gtm_pkg and goertzel_tone_magnitude_defines.svh.
`include "goertzel_tone_magnitude_defines.svh"

module gtm_checker
  import gtm_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            last_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [MagW-1:0] magnitude_o
);

  // Blocks whose last sample has gone in and whose word has not come out.
  logic [3:0] pend_q;
  logic       last_in, word_out;

  assign last_in  = in_valid_i && !in_stall_o && last_i;
  assign word_out = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(last_in) - 4'(word_out);
    end
  end

  `GTM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result word dropped")
  `GTM_ASSERT(a_out_keep, out_valid_o && out_stall_i |=> $stable(magnitude_o), "word changed")
  `GTM_ASSERT(a_in_gap, in_valid_i && !in_stall_o |=> in_stall_o, "sample taken too soon")
  `GTM_NEVER(a_no_orphan, out_valid_o && (pend_q == 4'd0), "word without a finished block")
  `GTM_NEVER(a_pend_max, pend_q > 4'd5, "more blocks in flight than the pipeline holds")

endmodule

bind goertzel_tone_magnitude gtm_checker u_gtm_checker (.*);
